// ----- hdl/modexp_pkg.sv -----
// shared types and constants for the modular exponentiation block
// no dependencies
`timescale 1ns / 1ps

package modexp_pkg;

   localparam int WIDTH_DEF   = 16;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] REG_EXPONENT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MODULUS  = 2'd1;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_RED,
      OP_WR_BASE,
      OP_MUL_ACC,
      OP_MUL_SQ,
      OP_WR_ACC,
      OP_WR_SQ
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic exp_lsb;
      logic mod_zero;
   } dp_status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_BASE_RED,
      S_BASE_WR,
      S_NEXT,
      S_MUL_A,
      S_RED_A,
      S_WR_A,
      S_MUL_S,
      S_RED_S,
      S_WR_S,
      S_FINISH
   } ctl_state_type;

endpackage

// ----- hdl/modexp_dp.sv -----
// datapath: config registers, multiplier, bit-serial remainder, accumulator and square
// depends on modexp_pkg
`timescale 1ns / 1ps

module modexp_dp #(
   parameter int WIDTH = modexp_pkg::WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [modexp_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [WIDTH-1:0]                    csr_wdata,
   input  logic [WIDTH-1:0]                    req_base,
   input  modexp_pkg::dp_cmd_type              cmd,
   output modexp_pkg::dp_status_type           status,
   output logic [WIDTH-1:0]                    rsp_power,
   output logic                                rsp_zero_modulus
);
   import modexp_pkg::*;

   logic [WIDTH-1:0]   exp_cfg_ff;
   logic [WIDTH-1:0]   mod_ff;
   logic [WIDTH-1:0]   acc_ff;
   logic [WIDTH-1:0]   sq_ff;
   logic [WIDTH-1:0]   exp_ff;
   logic [2*WIDTH-1:0] prod_ff;
   logic [WIDTH-1:0]   rem_ff;
   logic [WIDTH-1:0]   power_ff;
   logic               zm_ff;

   logic [WIDTH-1:0]   mul_x;
   logic [2*WIDTH-1:0] prod_mul;
   logic [WIDTH:0]     r_ext;
   logic [WIDTH:0]     r_diff;
   logic [WIDTH-1:0]   rem_in;
   logic               mod_zero;
   logic               mod_one;

   assign mod_zero = (mod_ff == '0);
   assign mod_one  = (mod_ff == WIDTH'(1));

   assign mul_x    = (cmd.op == OP_MUL_ACC) ? acc_ff : sq_ff;
   assign prod_mul = mul_x * sq_ff;

   // one restoring step: shift in the next product bit, subtract modulus if it fits
   assign r_ext  = {rem_ff, prod_ff[2*WIDTH-1]};
   assign r_diff = r_ext - {1'b0, mod_ff};
   assign rem_in = (r_ext >= {1'b0, mod_ff}) ? r_diff[WIDTH-1:0] : r_ext[WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_cfg_ff <= '0;
         mod_ff     <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_EXPONENT: exp_cfg_ff <= csr_wdata;
            REG_MODULUS:  mod_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op) inside
         OP_LOAD: begin
            prod_ff <= {{WIDTH{1'b0}}, req_base};
            rem_ff  <= '0;
            acc_ff  <= mod_one ? '0 : WIDTH'(1);
            exp_ff  <= exp_cfg_ff;
         end
         OP_RED: begin
            prod_ff <= {prod_ff[2*WIDTH-2:0], 1'b0};
            rem_ff  <= rem_in;
         end
         OP_WR_BASE: begin
            sq_ff <= rem_ff;
         end
         OP_MUL_ACC, OP_MUL_SQ: begin
            prod_ff <= prod_mul;
            rem_ff  <= '0;
         end
         OP_WR_ACC: begin
            acc_ff <= rem_ff;
         end
         OP_WR_SQ: begin
            sq_ff  <= rem_ff;
            exp_ff <= {1'b0, exp_ff[WIDTH-1:1]};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         power_ff <= mod_zero ? '0 : acc_ff;
         zm_ff    <= mod_zero;
      end
   end

   assign status.exp_lsb  = exp_ff[0];
   assign status.mod_zero = mod_zero;
   assign rsp_power        = power_ff;
   assign rsp_zero_modulus = zm_ff;

endmodule

// ----- hdl/modexp_ctrl.sv -----
// controller: sequences the multiply and reduce steps, owns the handshakes
// depends on modexp_pkg
`timescale 1ns / 1ps

module modexp_ctrl #(
   parameter int WIDTH = modexp_pkg::WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  modexp_pkg::dp_status_type status,
   output modexp_pkg::dp_cmd_type    cmd
);
   import modexp_pkg::*;

   localparam int RED_CNT_W = $clog2(2 * WIDTH);
   localparam int BIT_CNT_W = $clog2(WIDTH);

   ctl_state_type        state_ff, state_in;
   logic [RED_CNT_W-1:0] red_cnt_ff, red_cnt_in;
   logic [BIT_CNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 red_last;

   assign red_last = (red_cnt_ff == RED_CNT_W'(2 * WIDTH - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         red_cnt_ff   <= '0;
         bit_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         red_cnt_ff   <= red_cnt_in;
         bit_cnt_ff   <= bit_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      red_cnt_in   = red_cnt_ff;
      bit_cnt_in   = bit_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.op       = OP_NONE;
      cmd.load_rsp = 1'b0;
      req_ready    = 1'b0;

      unique case (state_ff) inside
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (status.mod_zero) begin
                  state_in = S_FINISH;
               end else begin
                  cmd.op     = OP_LOAD;
                  red_cnt_in = '0;
                  state_in   = S_BASE_RED;
               end
            end
         end
         S_BASE_RED, S_RED_A, S_RED_S: begin
            cmd.op     = OP_RED;
            red_cnt_in = red_cnt_ff + 1'b1;
            if (red_last) begin
               red_cnt_in = '0;
               unique case (state_ff)
                  S_BASE_RED: state_in = S_BASE_WR;
                  S_RED_A:    state_in = S_WR_A;
                  default:    state_in = S_WR_S;
               endcase
            end
         end
         S_BASE_WR: begin
            cmd.op     = OP_WR_BASE;
            bit_cnt_in = '0;
            state_in   = S_NEXT;
         end
         S_NEXT: begin
            state_in = status.exp_lsb ? S_MUL_A : S_MUL_S;
         end
         S_MUL_A: begin
            cmd.op   = OP_MUL_ACC;
            state_in = S_RED_A;
         end
         S_WR_A: begin
            cmd.op   = OP_WR_ACC;
            state_in = S_MUL_S;
         end
         S_MUL_S: begin
            cmd.op   = OP_MUL_SQ;
            state_in = S_RED_S;
         end
         S_WR_S: begin
            cmd.op = OP_WR_SQ;
            if (bit_cnt_ff == BIT_CNT_W'(WIDTH - 1)) begin
               state_in = S_FINISH;
            end else begin
               bit_cnt_in = bit_cnt_ff + 1'b1;
               state_in   = S_NEXT;
            end
         end
         S_FINISH: begin
            // wait until the output register is free or being drained by a transfer
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- hdl/modular_exponentiation.sv -----
// After the req transfer the base is reduced, then for each exponent bit the accumulator
// is multiplied by the square if the bit is one, and the square is squared; the remainder
// after every multiply is built one bit per cycle. A zero modulus goes straight to the result.
// One item at a time; the next one is taken while the previous result still waits in the
// output register.
// Synchronous active-high reset clears exponent, modulus and all control state.
`timescale 1ns / 1ps

module modular_exponentiation #(
   parameter int WIDTH = modexp_pkg::WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [WIDTH-1:0]                   req_base,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [WIDTH-1:0]                   rsp_power,
   output logic                               rsp_zero_modulus,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [modexp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [WIDTH-1:0]                   csr_wdata
);
   import modexp_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   modexp_ctrl #(
      .WIDTH (WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   modexp_dp #(
      .WIDTH (WIDTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_valid && csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_base         (req_base),
      .cmd              (cmd),
      .status           (status),
      .rsp_power        (rsp_power),
      .rsp_zero_modulus (rsp_zero_modulus)
   );

   // an error result never carries a value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_modulus |-> rsp_power == '0)
      else $error("zero modulus result with nonzero power");

   // the block is busy right after taking an item
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input ready right after a transfer");

   // a new result only appears as the controller returns to idle
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("result raised while controller busy");

endmodule

// ----- tb/sv/testbench.sv -----
// self-checking testbench for the modular exponentiation block
// depends on modexp_pkg and modular_exponentiation; directed vectors then random traffic
`timescale 1ns / 1ps

module testbench;
   import modexp_pkg::*;

   localparam int WIDTH          = WIDTH_DEF;
   localparam int GROUPS         = 11;
   localparam int GROUP_ITEMS    = 16;
   localparam int HOLD_AT        = 40;
   localparam int HOLD_CYCLES    = 5000;
   localparam int SETTLE_CYCLES  = 1200;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int N_DIRECTED     = 21;

   // indexes the block has no register for
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED_2 = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED_3 = 2'd3;

   typedef struct packed {
      logic [WIDTH-1:0] power;
      logic             zero_modulus;
   } power_result_type;

   typedef struct packed {
      logic [WIDTH-1:0] exponent;
      logic [WIDTH-1:0] modulus;
      logic [WIDTH-1:0] base;
      logic             spare_writes;
      logic             typed;
      logic [WIDTH-1:0] typed_power;
      logic             typed_zero;
   } vector_row_type;

   logic                   clock;
   logic                   reset            = 1'b1;
   logic                   req_valid        = 1'b0;
   logic                   req_ready;
   logic [WIDTH-1:0]       req_base         = '0;
   logic                   rsp_valid;
   logic                   rsp_ready        = 1'b0;
   logic [WIDTH-1:0]       rsp_power;
   logic                   rsp_zero_modulus;
   logic                   csr_valid        = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index        = '0;
   logic [WIDTH-1:0]       csr_wdata        = '0;

   logic [WIDTH-1:0] cfg_exponent = '0;
   logic [WIDTH-1:0] cfg_modulus  = '0;
   power_result_type expected_powers[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int error_count   = 0;
   int bases_sent    = 0;
   int results_seen  = 0;
   int csr_writes    = 0;
   int settings_used = 0;
   int hold_left     = 0;
   bit hold_done     = 1'b0;

   vector_row_type directed_rows [0:N_DIRECTED-1] = '{
      '{16'h0000, 16'h0000, 16'h1234, 1'b0, 1'b1, 16'h0000, 1'b1},
      '{16'h0000, 16'h0000, 16'hffff, 1'b0, 1'b1, 16'h0000, 1'b1},
      '{16'hffff, 16'h0000, 16'h0005, 1'b0, 1'b1, 16'h0000, 1'b1},
      '{16'h0000, 16'h0001, 16'h0007, 1'b0, 1'b1, 16'h0000, 1'b0},
      '{16'hffff, 16'h0001, 16'hffff, 1'b0, 1'b1, 16'h0000, 1'b0},
      '{16'h0000, 16'hffff, 16'h0000, 1'b0, 1'b1, 16'h0001, 1'b0},
      '{16'h0000, 16'h0007, 16'h0003, 1'b0, 1'b1, 16'h0001, 1'b0},
      '{16'h0001, 16'hffff, 16'hffff, 1'b0, 1'b1, 16'h0000, 1'b0},
      '{16'h0001, 16'hffff, 16'hfffe, 1'b0, 1'b1, 16'hfffe, 1'b0},
      '{16'h0001, 16'd10,   16'h0123, 1'b0, 1'b1, 16'h0001, 1'b0},
      '{16'h0002, 16'd1000, 16'd37,   1'b0, 1'b1, 16'd369,  1'b0},
      '{16'hffff, 16'hffff, 16'h0002, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{16'hffff, 16'hfffb, 16'hffff, 1'b1, 1'b0, 16'h0000, 1'b0},
      '{16'hffff, 16'hfffb, 16'h0000, 1'b1, 1'b1, 16'h0000, 1'b0},
      '{16'h8000, 16'hfff1, 16'h0003, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{16'h0003, 16'hffff, 16'h0000, 1'b0, 1'b1, 16'h0000, 1'b0},
      '{16'h5555, 16'haaaa, 16'haaaa, 1'b0, 1'b1, 16'h0000, 1'b0},
      '{16'haaaa, 16'h5555, 16'h1234, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{16'hffff, 16'h0002, 16'h0003, 1'b0, 1'b1, 16'h0001, 1'b0},
      '{16'h0010, 16'h8000, 16'h8001, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{16'hffff, 16'hffff, 16'hffff, 1'b0, 1'b1, 16'h0000, 1'b0}
   };

   modular_exponentiation #(.WIDTH(WIDTH)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_base         (req_base),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_power        (rsp_power),
      .rsp_zero_modulus (rsp_zero_modulus),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // right-to-left square and multiply, every product reduced by the modulus
   function automatic power_result_type power_mod(input logic [WIDTH-1:0] b,
                                                  input logic [WIDTH-1:0] e,
                                                  input logic [WIDTH-1:0] m);
      power_result_type   r;
      logic [2*WIDTH-1:0] acc;
      logic [2*WIDTH-1:0] sq;
      logic [2*WIDTH-1:0] mw;
      mw = {{WIDTH{1'b0}}, m};
      r.zero_modulus = (m == '0);
      r.power = '0;
      if (m != '0) begin
         acc = {{(2*WIDTH-1){1'b0}}, 1'b1};
         acc = acc % mw;
         sq = {{WIDTH{1'b0}}, b};
         sq = sq % mw;
         for (int i = 0; i < WIDTH; i++) begin
            if (e[i]) begin
               acc = (acc * sq) % mw;
            end
            sq = (sq * sq) % mw;
         end
         r.power = acc[WIDTH-1:0];
      end
      return r;
   endfunction

   task automatic send_base(input logic [WIDTH-1:0] b, input bit typed,
                            input power_result_type typed_result);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_base  <= b;
      do @(posedge clock); while (!req_ready);
      if (typed) begin
         expected_powers.push_back(typed_result);
      end else begin
         expected_powers.push_back(power_mod(b, cfg_exponent, cfg_modulus));
      end
      bases_sent++;
   endtask

   // sender pauses until every outstanding result has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_powers.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == REG_EXPONENT) begin
         cfg_exponent = data;
      end else if (idx == REG_MODULUS) begin
         cfg_modulus = data;
      end
      csr_writes++;
   endtask

   task automatic apply_config(input logic [WIDTH-1:0] e, input logic [WIDTH-1:0] m,
                               input bit spare);
      drain_results();
      if (spare) begin
         write_csr(REG_UNUSED_2, WIDTH'($urandom));
         write_csr(REG_UNUSED_3, WIDTH'($urandom));
      end
      if ($urandom_range(1) == 0) begin
         write_csr(REG_EXPONENT, e);
         write_csr(REG_MODULUS, m);
      end else begin
         write_csr(REG_MODULUS, m);
         write_csr(REG_EXPONENT, e);
      end
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // result checking and receiver stalls share one process so the transfer count is exact
   always @(posedge clock) begin
      power_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (expected_powers.size() == 0) begin
               $error("unexpected result: power %h zero_modulus %b", rsp_power, rsp_zero_modulus);
               error_count++;
            end else begin
               want = expected_powers.pop_front();
               if (rsp_power !== want.power) begin
                  $error("power: expected %h, got %h", want.power, rsp_power);
                  error_count++;
               end
               if (rsp_zero_modulus !== want.zero_modulus) begin
                  $error("zero_modulus: expected %b, got %b", want.zero_modulus,
                         rsp_zero_modulus);
                  error_count++;
               end
            end
         end
         // one long hold-off so the block backs up and stalls its input
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!hold_done && results_seen >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
   end

   initial begin : stimulus
      vector_row_type   row;
      power_result_type typed_result;
      logic [WIDTH-1:0] e;
      logic [WIDTH-1:0] m;
      logic [WIDTH-1:0] b;
      int               send_pct [0:2];
      int               recv_pct [0:2];
      send_pct = '{20, 65, 0};
      recv_pct = '{65, 20, 0};

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // first rows run on the reset values of both registers
      for (int i = 0; i < N_DIRECTED; i++) begin
         row = directed_rows[i];
         if (row.exponent != cfg_exponent || row.modulus != cfg_modulus || row.spare_writes)
            apply_config(row.exponent, row.modulus, row.spare_writes);
         typed_result.power        = row.typed_power;
         typed_result.zero_modulus = row.typed_zero;
         send_base(row.base, row.typed, typed_result);
      end

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = send_pct[phase];
         recv_idle_pct = recv_pct[phase];
         for (int g = 0; g < GROUPS; g++) begin
            case ($urandom_range(5))
               0:       e = '0;
               1:       e = WIDTH'(1);
               2:       e = '1;
               3:       e = WIDTH'(1) << $urandom_range(WIDTH-1);
               default: e = WIDTH'($urandom);
            endcase
            case ($urandom_range(7))
               0:       m = '0;
               1:       m = WIDTH'(1);
               2:       m = WIDTH'(2);
               3:       m = '1;
               4:       m = WIDTH'($urandom_range(255, 3));
               default: m = WIDTH'($urandom);
            endcase
            apply_config(e, m, $urandom_range(3) == 0);
            for (int k = 0; k < GROUP_ITEMS; k++) begin
               case ($urandom_range(9))
                  0:       b = '0;
                  1:       b = '1;
                  2:       b = cfg_modulus;
                  3:       b = cfg_modulus - 1'b1;
                  default: b = WIDTH'($urandom);
               endcase
               send_base(b, 1'b0, typed_result);
            end
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("sent %0d bases under %0d register settings (%0d register writes)",
               bases_sent, settings_used, csr_writes);
      $display("checked %0d results, %0d mismatches", results_seen, error_count);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/modexp_pkg.sv
hdl/modexp_dp.sv
hdl/modexp_ctrl.sv
hdl/modular_exponentiation.sv
tb/sv/testbench.sv
